/* rtl/eul3_pkg.sv */
`default_nettype none

package eul3_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int STATE_BITS_DEF = 48;
    localparam int COUNT_BITS_DEF = 16;

    localparam int MUL_CHUNK = 16;

    localparam int X_W       = 32;
    localparam int IDX_W     = 16;
    localparam int Y_W       = 32;
    localparam int STEP_W    = 17;
    localparam int COEF_W    = 24;
    localparam int POLE_W    = 23;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int UPC_W     = 5;

    localparam logic [STEP_W-1:0] STEP_RST = 17'd3277;
    localparam logic [COEF_W-1:0] GAIN_RST = 24'd196608;
    localparam logic [COEF_W-1:0] A1_RST   = 24'd327680;
    localparam logic [COEF_W-1:0] A2_RST   = 24'd196608;
    localparam logic [POLE_W-1:0] B1_RST   = 23'd196608;
    localparam logic [POLE_W-1:0] B2_RST   = 23'd131072;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_GAIN       = 3'd1,
        REG_ZERO_A_ONE = 3'd2,
        REG_ZERO_A_TWO = 3'd3,
        REG_POLE_B_ONE = 3'd4,
        REG_POLE_B_TWO = 3'd5
    } cfg_sel_t;

    typedef enum logic [3:0] {
        SRC_X  = 4'd0,
        SRC_H  = 4'd1,
        SRC_K  = 4'd2,
        SRC_A1 = 4'd3,
        SRC_A2 = 4'd4,
        SRC_B1 = 4'd5,
        SRC_B2 = 4'd6,
        SRC_Z1 = 4'd7,
        SRC_Z2 = 4'd8,
        SRC_Z3 = 4'd9,
        SRC_T  = 4'd10,
        SRC_U  = 4'd11,
        SRC_Y  = 4'd12,
        SRC_N  = 4'd13
    } src_t;

    typedef enum logic [2:0] {
        OP_NOP    = 3'd0,
        OP_ADD    = 3'd1,
        OP_SUB    = 3'd2,
        OP_MUL    = 3'd3,
        OP_DIV    = 3'd4,
        OP_SAT32  = 3'd5,
        OP_SGNSAT = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        JC_NONE   = 2'd0,
        JC_ALWAYS = 2'd1,
        JC_POS    = 2'd2
    } cond_t;

    typedef struct packed {
        op_t              op;
        src_t             dst;
        src_t             sa;
        src_t             sb;
        cond_t            cond;
        logic [UPC_W-1:0] target;
        logic             last;
    } uword_t;

    function automatic uword_t mk(input op_t op, input src_t d, input src_t a, input src_t b,
                                  input cond_t c, input logic [UPC_W-1:0] t, input logic l);
        uword_t w;
        w.op     = op;
        w.dst    = d;
        w.sa     = a;
        w.sb     = b;
        w.cond   = c;
        w.target = t;
        w.last   = l;
        return w;
    endfunction

    // one tick: output y, then e1, e2 and the numerator, den, quotient, state update
    function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
        uword_t w;
        case (pc)
            5'd0:    w = mk(OP_SUB,    SRC_T,  SRC_A1, SRC_A2, JC_NONE,   5'd0,  1'b0);
            5'd1:    w = mk(OP_MUL,    SRC_U,  SRC_K,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd2:    w = mk(OP_MUL,    SRC_T,  SRC_A1, SRC_A2, JC_NONE,   5'd0,  1'b0);
            5'd3:    w = mk(OP_MUL,    SRC_T,  SRC_T,  SRC_K,  JC_NONE,   5'd0,  1'b0);
            5'd4:    w = mk(OP_MUL,    SRC_Y,  SRC_K,  SRC_Z1, JC_NONE,   5'd0,  1'b0);
            5'd5:    w = mk(OP_MUL,    SRC_U,  SRC_U,  SRC_Z2, JC_NONE,   5'd0,  1'b0);
            5'd6:    w = mk(OP_ADD,    SRC_Y,  SRC_Y,  SRC_U,  JC_NONE,   5'd0,  1'b0);
            5'd7:    w = mk(OP_MUL,    SRC_T,  SRC_T,  SRC_Z3, JC_NONE,   5'd0,  1'b0);
            5'd8:    w = mk(OP_SUB,    SRC_Y,  SRC_Y,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd9:    w = mk(OP_SAT32,  SRC_Y,  SRC_Y,  SRC_Y,  JC_NONE,   5'd0,  1'b0);
            5'd10:   w = mk(OP_ADD,    SRC_T,  SRC_B1, SRC_B1, JC_NONE,   5'd0,  1'b0);
            5'd11:   w = mk(OP_ADD,    SRC_T,  SRC_T,  SRC_B2, JC_NONE,   5'd0,  1'b0);
            5'd12:   w = mk(OP_SUB,    SRC_N,  SRC_X,  SRC_Z1, JC_NONE,   5'd0,  1'b0);
            5'd13:   w = mk(OP_MUL,    SRC_T,  SRC_T,  SRC_Z2, JC_NONE,   5'd0,  1'b0);
            5'd14:   w = mk(OP_SUB,    SRC_N,  SRC_N,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd15:   w = mk(OP_MUL,    SRC_T,  SRC_B1, SRC_B2, JC_NONE,   5'd0,  1'b0);
            5'd16:   w = mk(OP_ADD,    SRC_T,  SRC_T,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd17:   w = mk(OP_MUL,    SRC_U,  SRC_B1, SRC_B1, JC_NONE,   5'd0,  1'b0);
            5'd18:   w = mk(OP_ADD,    SRC_T,  SRC_T,  SRC_U,  JC_NONE,   5'd0,  1'b0);
            5'd19:   w = mk(OP_MUL,    SRC_T,  SRC_T,  SRC_Z3, JC_NONE,   5'd0,  1'b0);
            5'd20:   w = mk(OP_SUB,    SRC_N,  SRC_N,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd21:   w = mk(OP_MUL,    SRC_T,  SRC_B2, SRC_B1, JC_NONE,   5'd0,  1'b0);
            5'd22:   w = mk(OP_MUL,    SRC_T,  SRC_T,  SRC_B1, JC_NONE,   5'd0,  1'b0);
            5'd23:   w = mk(OP_NOP,    SRC_T,  SRC_T,  SRC_T,  JC_POS,    5'd25, 1'b0);
            5'd24:   w = mk(OP_SGNSAT, SRC_N,  SRC_N,  SRC_N,  JC_ALWAYS, 5'd26, 1'b0);
            5'd25:   w = mk(OP_DIV,    SRC_N,  SRC_N,  SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd26:   w = mk(OP_MUL,    SRC_T,  SRC_H,  SRC_Z2, JC_NONE,   5'd0,  1'b0);
            5'd27:   w = mk(OP_ADD,    SRC_Z1, SRC_Z1, SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd28:   w = mk(OP_MUL,    SRC_T,  SRC_H,  SRC_Z3, JC_NONE,   5'd0,  1'b0);
            5'd29:   w = mk(OP_ADD,    SRC_Z2, SRC_Z2, SRC_T,  JC_NONE,   5'd0,  1'b0);
            5'd30:   w = mk(OP_MUL,    SRC_T,  SRC_H,  SRC_N,  JC_NONE,   5'd0,  1'b0);
            5'd31:   w = mk(OP_ADD,    SRC_Z3, SRC_Z3, SRC_T,  JC_NONE,   5'd0,  1'b1);
            default: w = mk(OP_NOP,    SRC_T,  SRC_T,  SRC_T,  JC_NONE,   5'd0,  1'b1);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/euler_third_order_system_step.sv */
`default_nettype none

// Third-order plant stepped by forward Euler in signed fixed point. Each input beat is one
// tick: the drive sample on s_tdata, the restart flag on s_tuser (clears the states and the
// tick count before the tick). Each tick gives one output beat with the tick number, the plant
// output taken from the states before the update, and a flag set when any value clipped.
// A 32-step microprogram drives one 16-bit-sliced multiplier and a one-bit-per-cycle divider;
// the divider is skipped when the denominator b2*b1*b1 is zero. s_tready is high only
// between ticks; a waiting result sits in the output register, and the next tick is accepted
// and computed but waits in its done step until that register is free. The user must write
// the configuration registers through cfg_we/cfg_index/cfg_data only between ticks; the
// block itself does not enforce this.
module euler_third_order_system_step #(
    parameter int FRAC_BITS  = eul3_pkg::FRAC_BITS_DEF,
    parameter int STATE_BITS = eul3_pkg::STATE_BITS_DEF,
    parameter int COUNT_BITS = eul3_pkg::COUNT_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       s_tvalid,
    output logic                                       s_tready,
    input  logic [eul3_pkg::X_W-1:0]                   s_tdata,   // drive_sample
    input  logic                                       s_tuser,   // restart
    output logic                                       m_tvalid,
    input  logic                                       m_tready,
    output logic [eul3_pkg::IDX_W+eul3_pkg::Y_W-1:0]   m_tdata,   // step_index, plant_output
    output logic                                       m_tuser,   // saturated
    input  logic                                       cfg_we,
    input  logic [eul3_pkg::CFG_IDX_W-1:0]             cfg_index,
    input  logic [eul3_pkg::CFG_W-1:0]                 cfg_data
);

    import eul3_pkg::*;

    localparam int SB  = STATE_BITS;
    localparam int NCH = (SB + MUL_CHUNK - 1) / MUL_CHUNK;
    localparam int BW  = NCH * MUL_CHUNK;
    localparam int PW  = SB + BW;
    localparam int DW  = SB + FRAC_BITS;
    localparam int MCW = $clog2(NCH + 1);
    localparam int DCW = $clog2(DW + 1);

    localparam logic signed [SB-1:0] SMAX  = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SMIN  = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] Y_MAX = SB'(64'(2**(Y_W-1) - 1));
    localparam logic signed [SB-1:0] Y_MIN = ~Y_MAX;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FETCH  = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_MULFIN = 7'b0001000,
        ST_DIV    = 7'b0010000,
        ST_DIVFIN = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [UPC_W-1:0] pc_reg, pc_next;

    logic [STEP_W-1:0]        step_size_reg, step_size_next;
    logic signed [COEF_W-1:0] gain_reg, gain_next;
    logic signed [COEF_W-1:0] a1_reg, a1_next;
    logic signed [COEF_W-1:0] a2_reg, a2_next;
    logic [POLE_W-1:0]        b1_reg, b1_next;
    logic [POLE_W-1:0]        b2_reg, b2_next;

    logic signed [SB-1:0] z1_reg, z1_next;
    logic signed [SB-1:0] z2_reg, z2_next;
    logic signed [SB-1:0] z3_reg, z3_next;
    logic signed [SB-1:0] t_reg, t_next;
    logic signed [SB-1:0] u_reg, u_next;
    logic signed [SB-1:0] y_reg, y_next;
    logic signed [SB-1:0] n_reg, n_next;
    logic signed [X_W-1:0] x_reg, x_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  clip_reg, clip_next;

    logic [SB-1:0]  amag_reg, amag_next;
    logic [BW-1:0]  bmag_reg, bmag_next;
    logic           neg_reg, neg_next;
    logic [PW-1:0]  acc_reg, acc_next;
    logic [MCW-1:0] cnt_reg, cnt_next;

    logic [SB-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  dq_reg, dq_next;
    logic [SB-1:0]  den_reg, den_next;
    logic [DCW-1:0] dcnt_reg, dcnt_next;

    logic             m_tvalid_reg, m_tvalid_next;
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [Y_W-1:0]   out_y_reg, out_y_next;
    logic             out_sat_reg, out_sat_next;

    uword_t uw;
    logic signed [SB-1:0] opa, opb;
    logic [SB-1:0] opa_mag, opb_mag;
    logic signed [SB-1:0] x_ext, h_ext, k_ext, a1_ext, a2_ext, b1_ext, b2_ext;

    logic signed [SB:0]   sum_w, diff_w;
    logic signed [SB-1:0] alu_res;
    logic                 alu_clip;

    logic [SB+MUL_CHUNK-1:0] pp;
    logic signed [PW:0]      prod_s, prod_sh;
    logic                    mul_fit;
    logic signed [SB-1:0]    mul_res;

    logic [SB:0]          trial, trial_sub;
    logic                 ge;
    logic                 q_hi_nz;
    logic signed [SB-1:0] div_res;
    logic                 div_clip;

    logic             jump_take;
    logic [UPC_W-1:0] pc_adv;
    state_t           st_adv;
    logic             wr_en;
    logic signed [SB-1:0] wr_val;
    logic [IDX_W+COUNT_BITS-1:0] idx_wide;

    assign uw = ucode(pc_reg);

    assign x_ext  = SB'(x_reg);
    assign h_ext  = SB'(step_size_reg);
    assign k_ext  = SB'(gain_reg);
    assign a1_ext = SB'(a1_reg);
    assign a2_ext = SB'(a2_reg);
    assign b1_ext = SB'(b1_reg);
    assign b2_ext = SB'(b2_reg);

    always_comb
    begin
        case (uw.sa)
            SRC_X:   opa = x_ext;
            SRC_H:   opa = h_ext;
            SRC_K:   opa = k_ext;
            SRC_A1:  opa = a1_ext;
            SRC_A2:  opa = a2_ext;
            SRC_B1:  opa = b1_ext;
            SRC_B2:  opa = b2_ext;
            SRC_Z1:  opa = z1_reg;
            SRC_Z2:  opa = z2_reg;
            SRC_Z3:  opa = z3_reg;
            SRC_T:   opa = t_reg;
            SRC_U:   opa = u_reg;
            SRC_Y:   opa = y_reg;
            SRC_N:   opa = n_reg;
            default: opa = '0;
        endcase
    end

    always_comb
    begin
        case (uw.sb)
            SRC_X:   opb = x_ext;
            SRC_H:   opb = h_ext;
            SRC_K:   opb = k_ext;
            SRC_A1:  opb = a1_ext;
            SRC_A2:  opb = a2_ext;
            SRC_B1:  opb = b1_ext;
            SRC_B2:  opb = b2_ext;
            SRC_Z1:  opb = z1_reg;
            SRC_Z2:  opb = z2_reg;
            SRC_Z3:  opb = z3_reg;
            SRC_T:   opb = t_reg;
            SRC_U:   opb = u_reg;
            SRC_Y:   opb = y_reg;
            SRC_N:   opb = n_reg;
            default: opb = '0;
        endcase
    end

    assign opa_mag = opa[SB-1] ? (~opa + 1'b1) : opa;
    assign opb_mag = opb[SB-1] ? (~opb + 1'b1) : opb;

    // saturating alu
    assign sum_w  = {opa[SB-1], opa} + {opb[SB-1], opb};
    assign diff_w = {opa[SB-1], opa} - {opb[SB-1], opb};

    always_comb
    begin
        alu_res  = opa;
        alu_clip = 1'b0;
        case (uw.op)
            OP_ADD:
            begin
                if (sum_w[SB] != sum_w[SB-1])
                begin
                    alu_clip = 1'b1;
                    alu_res  = sum_w[SB] ? SMIN : SMAX;
                end
                else
                begin
                    alu_res = sum_w[SB-1:0];
                end
            end
            OP_SUB:
            begin
                if (diff_w[SB] != diff_w[SB-1])
                begin
                    alu_clip = 1'b1;
                    alu_res  = diff_w[SB] ? SMIN : SMAX;
                end
                else
                begin
                    alu_res = diff_w[SB-1:0];
                end
            end
            OP_SAT32:
            begin
                if (!((&opa[SB-1:Y_W-1]) || !(|opa[SB-1:Y_W-1])))
                begin
                    alu_clip = 1'b1;
                    alu_res  = opa[SB-1] ? Y_MIN : Y_MAX;
                end
            end
            OP_SGNSAT:
            begin
                if (opa[SB-1])
                begin
                    alu_clip = 1'b1;
                    alu_res  = SMIN;
                end
                else if (opa != '0)
                begin
                    alu_clip = 1'b1;
                    alu_res  = SMAX;
                end
            end
            default:
            begin
                alu_res  = opa;
                alu_clip = 1'b0;
            end
        endcase
    end

    // multiplier, top slice of b first
    assign pp      = amag_reg * bmag_reg[BW-1 -: MUL_CHUNK];
    assign prod_s  = neg_reg ? -$signed({1'b0, acc_reg}) : $signed({1'b0, acc_reg});
    assign prod_sh = prod_s >>> FRAC_BITS;
    assign mul_fit = (&prod_sh[PW:SB-1]) || !(|prod_sh[PW:SB-1]);
    assign mul_res = mul_fit ? prod_sh[SB-1:0] : (prod_sh[PW] ? SMIN : SMAX);

    // restoring divider
    assign trial     = {rem_reg, dq_reg[DW-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};
    assign q_hi_nz   = |dq_reg[DW-1:SB];

    always_comb
    begin
        if (neg_reg)
        begin
            div_clip = q_hi_nz || (dq_reg[SB-1] && (|dq_reg[SB-2:0]));
            div_res  = div_clip ? SMIN : (~dq_reg[SB-1:0] + 1'b1);
        end
        else
        begin
            div_clip = q_hi_nz || dq_reg[SB-1];
            div_res  = div_clip ? SMAX : dq_reg[SB-1:0];
        end
    end

    // sequencing
    assign jump_take = (uw.cond == JC_ALWAYS) ||
                       ((uw.cond == JC_POS) && !opa[SB-1] && (opa != '0));
    assign pc_adv    = jump_take ? uw.target : (pc_reg + 1'b1);
    assign st_adv    = uw.last ? ST_DONE : ST_FETCH;

    assign idx_wide  = {{IDX_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        step_size_next = step_size_reg;
        gain_next      = gain_reg;
        a1_next        = a1_reg;
        a2_next        = a2_reg;
        b1_next        = b1_reg;
        b2_next        = b2_reg;
        z1_next        = z1_reg;
        z2_next        = z2_reg;
        z3_next        = z3_reg;
        t_next         = t_reg;
        u_next         = u_reg;
        y_next         = y_reg;
        n_next         = n_reg;
        x_next         = x_reg;
        count_next     = count_reg;
        clip_next      = clip_reg;
        amag_next      = amag_reg;
        bmag_next      = bmag_reg;
        neg_next       = neg_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        dq_next        = dq_reg;
        den_next       = den_reg;
        dcnt_next      = dcnt_reg;
        m_tvalid_next  = m_tvalid_reg;
        out_idx_next   = out_idx_reg;
        out_y_next     = out_y_reg;
        out_sat_next   = out_sat_reg;
        wr_en          = 1'b0;
        wr_val         = alu_res;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_STEP_SIZE:  step_size_next = cfg_data[STEP_W-1:0];
                REG_GAIN:       gain_next      = cfg_data[COEF_W-1:0];
                REG_ZERO_A_ONE: a1_next        = cfg_data[COEF_W-1:0];
                REG_ZERO_A_TWO: a2_next        = cfg_data[COEF_W-1:0];
                REG_POLE_B_ONE: b1_next        = cfg_data[POLE_W-1:0];
                REG_POLE_B_TWO: b2_next        = cfg_data[POLE_W-1:0];
                default:        ;
            endcase
        end

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata;
                    clip_next  = 1'b0;
                    pc_next    = '0;
                    state_next = ST_FETCH;
                    if (s_tuser)
                    begin
                        z1_next    = '0;
                        z2_next    = '0;
                        z3_next    = '0;
                        count_next = COUNT_BITS'(1);
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                case (uw.op)
                    OP_MUL:
                    begin
                        amag_next  = opa_mag;
                        bmag_next  = BW'(opb_mag);
                        neg_next   = opa[SB-1] ^ opb[SB-1];
                        acc_next   = '0;
                        cnt_next   = MCW'(NCH);
                        state_next = ST_MUL;
                    end
                    OP_DIV:
                    begin
                        neg_next   = opa[SB-1];
                        dq_next    = {opa_mag, {FRAC_BITS{1'b0}}};
                        den_next   = opb;
                        rem_next   = '0;
                        dcnt_next  = DCW'(DW);
                        state_next = ST_DIV;
                    end
                    default:
                    begin
                        wr_en      = (uw.op != OP_NOP);
                        wr_val     = alu_res;
                        clip_next  = clip_reg | alu_clip;
                        pc_next    = pc_adv;
                        state_next = st_adv;
                    end
                endcase
            end
            ST_MUL:
            begin
                acc_next  = (acc_reg << MUL_CHUNK) + PW'(pp);
                bmag_next = bmag_reg << MUL_CHUNK;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == MCW'(1))
                begin
                    state_next = ST_MULFIN;
                end
            end
            ST_MULFIN:
            begin
                wr_en      = 1'b1;
                wr_val     = mul_res;
                clip_next  = clip_reg | !mul_fit;
                pc_next    = pc_adv;
                state_next = st_adv;
            end
            ST_DIV:
            begin
                rem_next  = ge ? trial_sub[SB-1:0] : trial[SB-1:0];
                dq_next   = {dq_reg[DW-2:0], ge};
                dcnt_next = dcnt_reg - 1'b1;
                if (dcnt_reg == DCW'(1))
                begin
                    state_next = ST_DIVFIN;
                end
            end
            ST_DIVFIN:
            begin
                wr_en      = 1'b1;
                wr_val     = div_res;
                clip_next  = clip_reg | div_clip;
                pc_next    = pc_adv;
                state_next = st_adv;
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    out_idx_next  = idx_wide[IDX_W-1:0];
                    out_y_next    = y_reg[Y_W-1:0];
                    out_sat_next  = clip_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (wr_en)
        begin
            case (uw.dst)
                SRC_Z1:  z1_next = wr_val;
                SRC_Z2:  z2_next = wr_val;
                SRC_Z3:  z3_next = wr_val;
                SRC_T:   t_next  = wr_val;
                SRC_U:   u_next  = wr_val;
                SRC_Y:   y_next  = wr_val;
                SRC_N:   n_next  = wr_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= '0;
            step_size_reg <= STEP_RST;
            gain_reg      <= GAIN_RST;
            a1_reg        <= A1_RST;
            a2_reg        <= A2_RST;
            b1_reg        <= B1_RST;
            b2_reg        <= B2_RST;
            z1_reg        <= '0;
            z2_reg        <= '0;
            z3_reg        <= '0;
            count_reg     <= '0;
            cnt_reg       <= '0;
            dcnt_reg      <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            step_size_reg <= step_size_next;
            gain_reg      <= gain_next;
            a1_reg        <= a1_next;
            a2_reg        <= a2_next;
            b1_reg        <= b1_next;
            b2_reg        <= b2_next;
            z1_reg        <= z1_next;
            z2_reg        <= z2_next;
            z3_reg        <= z3_next;
            count_reg     <= count_next;
            cnt_reg       <= cnt_next;
            dcnt_reg      <= dcnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        u_reg       <= u_next;
        y_reg       <= y_next;
        n_reg       <= n_next;
        x_reg       <= x_next;
        clip_reg    <= clip_next;
        amag_reg    <= amag_next;
        bmag_reg    <= bmag_next;
        neg_reg     <= neg_next;
        acc_reg     <= acc_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
        den_reg     <= den_next;
        out_idx_reg <= out_idx_next;
        out_y_reg   <= out_y_next;
        out_sat_reg <= out_sat_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_y_reg, out_idx_reg};
    assign m_tuser  = out_sat_reg;

`ifndef SYNTH
    a_div_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FETCH && uw.op == OP_DIV) |-> (!opb[SB-1] && opb != '0))
        else $error("divider started with a non-positive divisor");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result beat raised outside the done step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == ST_FETCH && pc_reg == '0))
        else $error("accepted beat did not start the microprogram");

    a_mul_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MULFIN) |-> (cnt_reg == '0))
        else $error("multiplier finished with slices left");
`endif

endmodule

`default_nettype wire

/* bench/tb_euler_third_order_system_step.sv */
`default_nettype none

module tb_euler_third_order_system_step;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 1500;
    localparam int PHASES      = 16;
    localparam int PHASE_TICKS = 52;
    localparam int DRAIN_WAIT  = 200;

    localparam logic [2:0] REG_SPARE_SIX   = 3'd6;
    localparam logic [2:0] REG_SPARE_SEVEN = 3'd7;

    localparam eul3_pkg::cfg_sel_t REG_ORDER [6] = '{
        eul3_pkg::REG_STEP_SIZE, eul3_pkg::REG_GAIN, eul3_pkg::REG_ZERO_A_ONE,
        eul3_pkg::REG_ZERO_A_TWO, eul3_pkg::REG_POLE_B_ONE, eul3_pkg::REG_POLE_B_TWO
    };

    // restart flag above the drive sample
    localparam logic [32:0] DIRECTED [20] = '{
        {1'b1, 32'h00000000}, {1'b0, 32'h7FFFFFFF}, {1'b0, 32'h7FFFFFFF},
        {1'b0, 32'h80000000}, {1'b0, 32'h00000000}, {1'b0, 32'h00000001},
        {1'b0, 32'hFFFFFFFF}, {1'b0, 32'h00010000}, {1'b0, 32'hFFFF0000},
        {1'b0, 32'hAAAAAAAA}, {1'b0, 32'h55555555}, {1'b1, 32'h80000000},
        {1'b0, 32'h80000000}, {1'b0, 32'h80000000}, {1'b1, 32'h7FFFFFFF},
        {1'b0, 32'h12345678}, {1'b0, 32'hFEDCBA98}, {1'b1, 32'h00000000},
        {1'b0, 32'h00030000}, {1'b0, 32'hFFFD0000}
    };

    typedef struct {
        logic [15:0] step_index;
        logic [31:0] plant_output;
        logic        saturated;
    } tick_result_t;

    class plant_checker;
        localparam longint STATE_MAX = (64'sd1 <<< 47) - 64'sd1;
        localparam longint STATE_MIN = -STATE_MAX - 64'sd1;
        localparam longint Y_MAX     = 64'sd2147483647;
        localparam longint Y_MIN     = -64'sd2147483648;

        logic [16:0]  step_h;
        logic [23:0]  gain_k, a_one, a_two;
        logic [22:0]  b_one, b_two;
        longint       pos_z, rate_z, accel_z;
        logic [15:0]  tick_no;
        bit           clip;
        tick_result_t expected_ticks [$];
        int           mismatches;
        int           ticks_seen;
        int           results_checked;
        int           clipped_ticks;

        function new();
            step_h  = eul3_pkg::STEP_RST;
            gain_k  = eul3_pkg::GAIN_RST;
            a_one   = eul3_pkg::A1_RST;
            a_two   = eul3_pkg::A2_RST;
            b_one   = eul3_pkg::B1_RST;
            b_two   = eul3_pkg::B2_RST;
            pos_z   = 0;
            rate_z  = 0;
            accel_z = 0;
            tick_no = '0;
        endfunction

        function longint clip_state(input longint v);
            if (v > STATE_MAX)
            begin
                clip = 1'b1;
                return STATE_MAX;
            end
            if (v < STATE_MIN)
            begin
                clip = 1'b1;
                return STATE_MIN;
            end
            return v;
        endfunction

        function longint fx_add(input longint a, input longint b);
            return clip_state(a + b);
        endfunction

        function longint fx_sub(input longint a, input longint b);
            return clip_state(a - b);
        endfunction

        // exact product, floor shift, then clip
        function longint fx_mul(input longint a, input longint b);
            logic signed [127:0] wa, wb, p;
            wa = a;
            wb = b;
            p  = (wa * wb) >>> eul3_pkg::FRAC_BITS_DEF;
            if (p > STATE_MAX)
            begin
                clip = 1'b1;
                return STATE_MAX;
            end
            if (p < STATE_MIN)
            begin
                clip = 1'b1;
                return STATE_MIN;
            end
            return longint'(p);
        endfunction

        function longint fx_div(input longint num, input longint den);
            logic signed [127:0] n, d;
            if (den <= 0)
            begin
                // zero divisor: clip by the sign of the numerator
                if (num > 0)
                begin
                    clip = 1'b1;
                    return STATE_MAX;
                end
                if (num < 0)
                begin
                    clip = 1'b1;
                    return STATE_MIN;
                end
                return 0;
            end
            n = num;
            d = den;
            n = (n <<< eul3_pkg::FRAC_BITS_DEF) / d;
            if (n > STATE_MAX)
            begin
                clip = 1'b1;
                return STATE_MAX;
            end
            if (n < STATE_MIN)
            begin
                clip = 1'b1;
                return STATE_MIN;
            end
            return longint'(n);
        endfunction

        function void write_reg(input logic [2:0] idx, input logic [23:0] val);
            case (idx)
                eul3_pkg::REG_STEP_SIZE:  step_h = val[16:0];
                eul3_pkg::REG_GAIN:       gain_k = val;
                eul3_pkg::REG_ZERO_A_ONE: a_one  = val;
                eul3_pkg::REG_ZERO_A_TWO: a_two  = val;
                eul3_pkg::REG_POLE_B_ONE: b_one  = val[22:0];
                eul3_pkg::REG_POLE_B_TWO: b_two  = val[22:0];
                default: ;
            endcase
        endfunction

        function void note_tick(input logic [31:0] drive, input logic restart);
            longint       x, h, k, a1, a2, b1, b2, z1, z2, z3;
            longint       c2, c3, e1, e2, den, y, num, q;
            tick_result_t res;
            clip = 1'b0;
            if (restart)
            begin
                pos_z   = 0;
                rate_z  = 0;
                accel_z = 0;
                tick_no = '0;
            end
            tick_no = tick_no + 16'd1;
            x  = $signed(drive);
            h  = step_h;
            k  = $signed(gain_k);
            a1 = $signed(a_one);
            a2 = $signed(a_two);
            b1 = b_one;
            b2 = b_two;
            z1 = pos_z;
            z2 = rate_z;
            z3 = accel_z;

            c2 = fx_mul(k, clip_state(a1 - a2));
            c3 = fx_mul(fx_mul(a1, a2), k);
            y  = fx_add(fx_mul(k, z1), fx_mul(c2, z2));
            y  = fx_sub(y, fx_mul(c3, z3));
            if (y > Y_MAX)
            begin
                clip = 1'b1;
                y    = Y_MAX;
            end
            if (y < Y_MIN)
            begin
                clip = 1'b1;
                y    = Y_MIN;
            end

            e1  = clip_state(2 * b1 + b2);
            e2  = fx_add(fx_add(fx_mul(b1, b2), fx_mul(b1, b2)), fx_mul(b1, b1));
            den = fx_mul(fx_mul(b2, b1), b1);
            num = fx_sub(clip_state(x), z1);
            num = fx_sub(num, fx_mul(e1, z2));
            num = fx_sub(num, fx_mul(e2, z3));
            q   = fx_div(num, den);

            pos_z   = fx_add(z1, fx_mul(h, z2));
            rate_z  = fx_add(z2, fx_mul(h, z3));
            accel_z = fx_add(z3, fx_mul(h, q));

            res.step_index   = tick_no;
            res.plant_output = y[31:0];
            res.saturated    = clip;
            expected_ticks.push_back(res);
            ticks_seen++;
            if (clip)
                clipped_ticks++;
        endfunction

        function void check_tick(input logic [15:0] idx, input logic [31:0] y,
                                 input logic sat);
            tick_result_t exp_res;
            results_checked++;
            if (expected_ticks.size() == 0)
            begin
                $display("%0t: unexpected result beat step_index %0d plant_output %0d",
                         $time, idx, $signed(y));
                mismatches++;
                return;
            end
            exp_res = expected_ticks.pop_front();
            if (idx !== exp_res.step_index)
            begin
                $display("%0t: step_index expected %0d actual %0d",
                         $time, exp_res.step_index, idx);
                mismatches++;
            end
            if (y !== exp_res.plant_output)
            begin
                $display("%0t: plant_output (tick %0d) expected %0d actual %0d",
                         $time, exp_res.step_index, $signed(exp_res.plant_output),
                         $signed(y));
                mismatches++;
            end
            if (sat !== exp_res.saturated)
            begin
                $display("%0t: saturated (tick %0d) expected %0b actual %0b",
                         $time, exp_res.step_index, exp_res.saturated, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tuser;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data  = '0;

    plant_checker sb = new();

    int send_idle_pct = 10;
    int recv_idle_pct = 63;
    int hold_requests = 0;
    int cycles        = 0;
    int settings_used = 1;

    euler_third_order_system_step i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #10 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.expected_ticks.size());
            $display("FAIL euler_third_order_system_step");
            $finish;
        end
    end

    // result side: check beats, random stalls and the long hold-off
    int hold_seen = 0;
    int hold_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                sb.check_tick(m_tdata[15:0], m_tdata[47:16], m_tuser);
            if (hold_seen != hold_requests)
            begin
                hold_seen = hold_requests;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_tick(input logic [31:0] drive, input logic restart);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= drive;
        s_tuser  <= restart;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_tick(drive, restart);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    function automatic logic [31:0] random_drive();
        logic [31:0] corners [5] = '{32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h1, 32'hFFFFFFFF};
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return corners[$urandom_range(0, 4)];
            default: return 32'($urandom_range(0, 1 << 22) - (1 << 21));
        endcase
    endfunction

    function automatic logic [23:0] random_reg_value(input eul3_pkg::cfg_sel_t sel);
        int unsigned step_corners [4] = '{0, 1, 65536, 131071};
        int unsigned coef_corners [4] = '{24'h7FFFFF, 24'h800000, 0, 24'hFFFFFF};
        int unsigned pole_corners [4] = '{0, 1, 65536, 24'h7FFFFF};
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return 24'($urandom);
        case (sel)
            eul3_pkg::REG_STEP_SIZE:
                return (pick == 1) ? 24'(step_corners[$urandom_range(0, 3)])
                                   : 24'($urandom_range(200, 8000));
            eul3_pkg::REG_POLE_B_ONE, eul3_pkg::REG_POLE_B_TWO:
                return (pick == 1) ? 24'(pole_corners[$urandom_range(0, 3)])
                                   : 24'($urandom_range(16384, 6 << 16));
            default:
                return (pick == 1) ? 24'(coef_corners[$urandom_range(0, 3)])
                                   : 24'($urandom_range(0, 16 << 16) - (8 << 16));
        endcase
    endfunction

    task automatic apply_setting(input int phase);
        logic [23:0] v [6];
        foreach (REG_ORDER[j])
            v[REG_ORDER[j]] = random_reg_value(REG_ORDER[j]);
        case (phase)
            1:
            begin
                v[eul3_pkg::REG_STEP_SIZE]  = 24'd65536;
                v[eul3_pkg::REG_GAIN]       = 24'h7FFFFF;
                v[eul3_pkg::REG_ZERO_A_ONE] = 24'h7FFFFF;
                v[eul3_pkg::REG_ZERO_A_TWO] = 24'h800000;
                v[eul3_pkg::REG_POLE_B_ONE] = 24'h7FFFFF;
                v[eul3_pkg::REG_POLE_B_TWO] = 24'h7FFFFF;
            end
            2:
            begin
                // frozen states, zero divisor
                v[eul3_pkg::REG_STEP_SIZE]  = 24'd0;
                v[eul3_pkg::REG_GAIN]       = 24'h800000;
                v[eul3_pkg::REG_ZERO_A_ONE] = 24'h800000;
                v[eul3_pkg::REG_ZERO_A_TWO] = 24'h7FFFFF;
                v[eul3_pkg::REG_POLE_B_ONE] = 24'd0;
                v[eul3_pkg::REG_POLE_B_TWO] = 24'd1;
            end
            3:
            begin
                // tiny poles: divisor rounds to zero
                v[eul3_pkg::REG_STEP_SIZE]  = 24'd65536;
                v[eul3_pkg::REG_POLE_B_ONE] = 24'd1;
                v[eul3_pkg::REG_POLE_B_TWO] = 24'd1;
            end
            4:
            begin
                v[eul3_pkg::REG_STEP_SIZE]  = 24'd1;
                v[eul3_pkg::REG_GAIN]       = 24'hFFFFFF;
                v[eul3_pkg::REG_ZERO_A_ONE] = 24'd0;
                v[eul3_pkg::REG_ZERO_A_TWO] = 24'd1;
                v[eul3_pkg::REG_POLE_B_ONE] = 24'd65536;
                v[eul3_pkg::REG_POLE_B_TWO] = 24'd65536;
            end
            5:
            begin
                // out-of-range bits above the register widths
                v[eul3_pkg::REG_STEP_SIZE]  = 24'hFFFFFF;
                v[eul3_pkg::REG_POLE_B_ONE] = 24'hFFFFFF;
            end
            default: ;
        endcase
        if (phase % 2 == 1)
        begin
            cfg_write(REG_SPARE_SIX, 24'($urandom));
            cfg_write(REG_SPARE_SEVEN, 24'($urandom));
        end
        foreach (REG_ORDER[j])
            cfg_write(REG_ORDER[j], v[REG_ORDER[j]]);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings first
        foreach (DIRECTED[i])
            send_tick(DIRECTED[i][31:0], DIRECTED[i][32]);

        for (int p = 1; p < PHASES; p++)
        begin
            s_tvalid <= 1'b0;
            while (sb.expected_ticks.size() != 0)
                @(posedge clk);
            apply_setting(p);
            settings_used++;
            if (p <= 5)
            begin
                send_idle_pct = 10;
                recv_idle_pct = 63;
            end
            else if (p <= 10)
            begin
                send_idle_pct = 63;
                recv_idle_pct = 10;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (p == 2 || p == 8)
                hold_requests++;
            if (p <= 4)
            begin
                send_tick(32'h00000000, 1'b1);
                send_tick(32'h7FFFFFFF, 1'b0);
                send_tick(32'h80000000, 1'b0);
                n = 3;
            end
            else
            begin
                send_tick(random_drive(), 1'b1);
                n = 1;
            end
            for (; n < PHASE_TICKS; n++)
                send_tick(random_drive(), $urandom_range(0, 31) == 0);
        end

        s_tvalid <= 1'b0;
        while (sb.expected_ticks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d ticks over %0d register settings including extremes and zero divisor",
                 sb.ticks_seen, settings_used);
        $display("checked %0d result beats, %0d of them with clipping",
                 sb.results_checked, sb.clipped_ticks);
        if (sb.mismatches == 0 && sb.expected_ticks.size() == 0)
            $display("PASS euler_third_order_system_step");
        else
            $display("FAIL euler_third_order_system_step");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/eul3_pkg.sv
rtl/euler_third_order_system_step.sv
bench/tb_euler_third_order_system_step.sv
